// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ----- rtl/rcsv_pkg.sv -----
package rcsv_pkg;

  localparam logic [11:0] CENTER     = 12'd1500;
  localparam logic [12:0] DEADZONE   = 13'd50;
  localparam logic [5:0]  NORM_DIV   = 6'd25;
  localparam int          NORM_BITS  = 20;
  localparam int          SQRT_STEPS = 23;
  localparam int          DIV_BITS   = 32;

  localparam logic [11:0] SW_RT_LO  = 12'd1800;
  localparam logic [11:0] SW_RT_HI  = 12'd2200;
  localparam logic [11:0] THR_LO    = 12'd1470;
  localparam logic [11:0] THR_HI    = 12'd1530;
  localparam logic [11:0] STK_LO    = 12'd1485;
  localparam logic [11:0] STK_HI    = 12'd1515;
  localparam logic [11:0] SW_PH_LO  = 12'd1300;
  localparam logic [11:0] SW_PH_HI  = 12'd1700;
  localparam logic [11:0] SW_MAN_LO = 12'd800;
  localparam logic [11:0] SW_MAN_HI = 12'd1200;

  localparam logic signed [13:0] F_ONE = 14'sd4096;

  localparam logic [9:0]  XY_RST   = 10'd500;
  localparam logic [9:0]  ZUP_RST  = 10'd350;
  localparam logic [9:0]  ZDN_RST  = 10'd250;
  localparam logic [15:0] HOLD_RST = 16'd1000;

  typedef enum logic [1:0] {
    CFG_XY_LIMIT = 2'd0,
    CFG_Z_UP     = 2'd1,
    CFG_Z_DOWN   = 2'd2,
    CFG_HOLD     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_RT   = 2'd1,
    MODE_HOLD = 2'd2,
    MODE_MAN  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_FILT,
    ST_MUL,
    ST_CLAMP,
    ST_SQ,
    ST_SUM,
    ST_SQRT,
    ST_DIVLD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

// ----- rtl/rc_stick_velocity_setpoint_top.sv -----
// Turns one radio-control frame into velocity and distance setpoints. A transaction
// is taken when in_valid is high and in_stall low. The bit-serial divide by 25 of
// the stick offsets comes first, then five steps for filter and mode, products,
// clamp, squares and length check, then, only when the horizontal vector has to be
// length-limited, the bit-serial square root of the squared XY length, a load step
// and the scaling division of X and Y; the result then enters the out_ registers.
// One frame is in work at a time; the next is taken once the result has entered the
// output register, and a finished result waits while a stalled earlier result holds
// the output register. Write the cfg_ registers only while the block is idle.
`include "assert_macros.svh"

module rc_stick_velocity_setpoint_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_roll_pulse,
  input  logic [11:0]        in_pitch_pulse,
  input  logic [11:0]        in_throttle_pulse,
  input  logic [11:0]        in_yaw_pulse,
  input  logic [11:0]        in_switch_pulse,
  input  logic signed [15:0] in_prog_vel_x,
  input  logic signed [15:0] in_prog_vel_y,
  input  logic signed [15:0] in_prog_vel_z,
  input  logic signed [15:0] in_prog_dist_x,
  input  logic signed [15:0] in_prog_dist_y,
  input  logic signed [15:0] in_prog_dist_z,
  input  logic signed [15:0] in_measured_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] out_vel_out_x,
  output logic signed [10:0] out_vel_out_y,
  output logic signed [10:0] out_vel_out_z,
  output logic signed [15:0] out_dist_out_x,
  output logic signed [15:0] out_dist_out_y,
  output logic signed [15:0] out_dist_out_z,
  output logic [1:0]         out_flight_mode
);
  import rcsv_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [9:0]  xy_r, zup_r, zdn_r;
  logic [15:0] hold_r;
  logic [15:0] frame_r, frame_nxt;
  mode_t       mode_r, mode_nxt;
  logic signed [13:0] fx_r, fy_r, fz_r;

  logic [11:0] roll_r, pitch_r, thr_r, yaw_r, sw_r;
  logic signed [15:0] pvx_r, pvy_r, pvz_r, dx_r, dy_r, dz_r, mh_r;

  logic signed [28:0] rx_r, ry_r, rz_r;
  logic signed [23:0] vx_r, vy_r, vz_r;
  logic [45:0]        sqx_r, sqy_r;
  logic               lim_r;

  logic               out_valid_r;
  logic signed [10:0] ovx_r, ovy_r, ovz_r;
  logic signed [15:0] odx_r, ody_r, odz_r;
  logic [1:0]         omode_r;

  lane_ctl_t norm_ctl, sqrt_ctl, div_ctl;
  logic signed [15:0] nx, ny, nz;
  logic [22:0]        root;
  logic signed [10:0] qx, qy;

  logic               accept, out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;
  assign out_load = state_r == ST_DONE && (!out_valid_r || !out_stall);

  rcsv_norm_lane u_norm_x (.clk, .ctl(norm_ctl), .pulse(in_roll_pulse), .n(nx));
  rcsv_norm_lane u_norm_y (.clk, .ctl(norm_ctl), .pulse(in_pitch_pulse), .n(ny));
  rcsv_norm_lane u_norm_z (.clk, .ctl(norm_ctl), .pulse(in_throttle_pulse), .n(nz));

  function automatic logic signed [13:0] filt_step(logic signed [13:0] f,
                                                   logic signed [15:0] n);
    logic signed [16:0] diff;
    logic signed [16:0] sum;
    diff = 17'(n) - 17'(f);
    sum  = 17'(f) + (diff >>> 1);
    if (sum > 17'(F_ONE)) begin
      return F_ONE;
    end else if (sum < -17'(F_ONE)) begin
      return -F_ONE;
    end
    return 14'(sum);
  endfunction

  function automatic logic in_open(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
    return v > lo && v < hi;
  endfunction

  function automatic logic signed [23:0] clamp(logic signed [28:0] v,
                                               logic [9:0] up, logic [9:0] dn);
    logic signed [28:0] hi;
    logic signed [28:0] lo;
    hi = $signed({7'b0, up, 12'b0});
    lo = -$signed({7'b0, dn, 12'b0});
    if (v > hi) begin
      return 24'(hi);
    end else if (v < lo) begin
      return 24'(lo);
    end
    return 24'(v);
  endfunction

  function automatic logic [21:0] mag22(logic signed [23:0] v);
    logic [23:0] a;
    a = v[23] ? 24'(-v) : 24'(v);
    return a[21:0];
  endfunction

  function automatic logic signed [10:0] trunc12(logic signed [23:0] v);
    logic [21:0] a;
    a = mag22(v);
    return v[23] ? -$signed({1'b0, a[21:12]}) : $signed({1'b0, a[21:12]});
  endfunction

  logic        rt_cond;
  logic [15:0] frame_inc;
  logic [19:0] ll;
  logic [45:0] s_sum;
  logic [45:0] s_lim;
  logic signed [24:0] mx, my;
  logic signed [24:0] mz;
  logic signed [15:0] pvx_s, pvy_s, pvz_s;
  logic signed [47:0] sqx_full, sqy_full;
  logic [31:0] numx, numy;

  always_comb begin
    rt_cond = in_open(sw_r, SW_RT_LO, SW_RT_HI) && in_open(thr_r, THR_LO, THR_HI) &&
              in_open(yaw_r, STK_LO, STK_HI) && in_open(pitch_r, STK_LO, STK_HI) &&
              in_open(roll_r, STK_LO, STK_HI);
    frame_inc = (frame_r == 16'hFFFF) ? frame_r : frame_r + 16'd1;
    mx = $signed({1'b0, xy_r}) * fx_r;
    my = $signed({1'b0, xy_r}) * fy_r;
    mz = $signed({1'b0, zup_r}) * fz_r;
    pvx_s = (mode_r == MODE_RT) ? pvx_r : '0;
    pvy_s = (mode_r == MODE_RT) ? pvy_r : '0;
    pvz_s = (mode_r == MODE_RT) ? pvz_r : '0;
    sqx_full = vx_r * vx_r;
    sqy_full = vy_r * vy_r;
    ll    = xy_r * xy_r;
    s_sum = sqx_r + sqy_r;
    s_lim = {2'b0, ll, 24'b0};
    numx  = mag22(vx_r) * xy_r;
    numy  = mag22(vy_r) * xy_r;
  end

  rcsv_sqrt u_sqrt (.clk, .ctl(sqrt_ctl), .s(s_sum), .root);
  rcsv_div_lane u_div_x (.clk, .ctl(div_ctl), .num(numx), .neg(vx_r[23]), .den(root),
                         .q(qx));
  rcsv_div_lane u_div_y (.clk, .ctl(div_ctl), .num(numy), .neg(vy_r[23]), .den(root),
                         .q(qy));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    mode_nxt  = mode_r;
    norm_ctl  = '{load: accept, step: 1'b0};
    sqrt_ctl  = '0;
    div_ctl   = '0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        norm_ctl.step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(NORM_BITS - 1)) state_nxt = ST_FILT;
      end
      ST_FILT: begin
        frame_nxt = frame_inc;
        if (rt_cond) begin
          if (frame_inc > hold_r) mode_nxt = MODE_RT;
        end else if (in_open(sw_r, SW_PH_LO, SW_PH_HI)) begin
          mode_nxt  = MODE_HOLD;
          frame_nxt = '0;
        end else if (in_open(sw_r, SW_MAN_LO, SW_MAN_HI)) begin
          mode_nxt  = MODE_MAN;
          frame_nxt = '0;
        end else begin
          frame_nxt = '0;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_SUM;
      ST_SUM: begin
        sqrt_ctl.load = 1'b1;
        cnt_nxt = '0;
        state_nxt = (s_sum > s_lim) ? ST_SQRT : ST_DONE;
      end
      ST_SQRT: begin
        sqrt_ctl.step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = ST_DIVLD;
      end
      ST_DIVLD: begin
        div_ctl.load = 1'b1;
        cnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_BITS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      frame_r     <= '0;
      mode_r      <= MODE_NONE;
      fx_r        <= '0;
      fy_r        <= '0;
      fz_r        <= '0;
      xy_r        <= XY_RST;
      zup_r       <= ZUP_RST;
      zdn_r       <= ZDN_RST;
      hold_r      <= HOLD_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      frame_r <= frame_nxt;
      mode_r  <= mode_nxt;
      if (state_r == ST_FILT) begin
        fx_r <= filt_step(fx_r, nx);
        fy_r <= filt_step(fy_r, ny);
        fz_r <= filt_step(fz_r, nz);
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_XY_LIMIT: xy_r   <= cfg_wdata[9:0];
          CFG_Z_UP:     zup_r  <= cfg_wdata[9:0];
          CFG_Z_DOWN:   zdn_r  <= cfg_wdata[9:0];
          CFG_HOLD:     hold_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      roll_r  <= in_roll_pulse;
      pitch_r <= in_pitch_pulse;
      thr_r   <= in_throttle_pulse;
      yaw_r   <= in_yaw_pulse;
      sw_r    <= in_switch_pulse;
      pvx_r   <= in_prog_vel_x;
      pvy_r   <= in_prog_vel_y;
      pvz_r   <= in_prog_vel_z;
      dx_r    <= in_prog_dist_x;
      dy_r    <= in_prog_dist_y;
      dz_r    <= in_prog_dist_z;
      mh_r    <= in_measured_height;
    end
    if (state_r == ST_MUL) begin
      if (mode_r == MODE_NONE) begin
        rx_r <= '0;
        ry_r <= '0;
        rz_r <= '0;
      end else begin
        rx_r <= 29'(mx) + $signed({pvx_s[15], pvx_s, 12'b0});
        ry_r <= 29'(my) + $signed({pvy_s[15], pvy_s, 12'b0});
        rz_r <= 29'(mz) + $signed({pvz_s[15], pvz_s, 12'b0});
      end
    end
    if (state_r == ST_CLAMP) begin
      vx_r <= clamp(rx_r, xy_r, xy_r);
      vy_r <= clamp(ry_r, xy_r, xy_r);
      vz_r <= clamp(rz_r, zup_r, zdn_r);
    end
    if (state_r == ST_SQ) begin
      sqx_r <= sqx_full[45:0];
      sqy_r <= sqy_full[45:0];
    end
    if (state_r == ST_SUM) begin
      lim_r <= s_sum > s_lim;
    end
    if (out_load) begin
      ovx_r   <= lim_r ? qx : trunc12(vx_r);
      ovy_r   <= lim_r ? qy : trunc12(vy_r);
      ovz_r   <= trunc12(vz_r);
      odx_r   <= dx_r;
      ody_r   <= dy_r;
      odz_r   <= (mode_r == MODE_HOLD) ? mh_r : dz_r;
      omode_r <= mode_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vel_out_x   = ovx_r;
  assign out_vel_out_y   = ovy_r;
  assign out_vel_out_z   = ovz_r;
  assign out_dist_out_x  = odx_r;
  assign out_dist_out_y  = ody_r;
  assign out_dist_out_z  = odz_r;
  assign out_flight_mode = omode_r;

  `ASSERT_CLK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE),
              "result without finish")
  `ASSERT_CLK(a_mode_sticky, mode_r != MODE_NONE |=> mode_r != MODE_NONE,
              "mode fell back to none")
  `ASSERT_CLK(a_filt_range, fx_r <= F_ONE && fx_r >= -F_ONE &&
              fz_r <= F_ONE && fz_r >= -F_ONE, "filter out of range")
  `ASSERT_CLK(a_vel_range, out_valid_r |-> ovx_r <= 11'sd1000 && ovx_r >= -11'sd1000,
              "x velocity out of range")
  `ASSERT_ANY(a_reset_idle, !rst_n |=> state_r == ST_IDLE && !out_valid_r,
              "reset did not idle")

endmodule

// ----- rtl/rcsv_norm_lane.sv -----
module rcsv_norm_lane (
  input  logic                clk,
  input  rcsv_pkg::lane_ctl_t ctl,
  input  logic [11:0]         pulse,
  output logic signed [15:0]  n
);
  import rcsv_pkg::*;

  logic [NORM_BITS-1:0] q_r, q_nxt;
  logic [4:0]           rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [12:0]   d;
  logic [11:0]          mag;
  logic [5:0]           t;
  logic                 ge;

  always_comb begin
    d = $signed({1'b0, pulse}) - $signed({1'b0, CENTER});
    if (d > $signed(DEADZONE)) begin
      mag = 12'(d - $signed(DEADZONE));
    end else if (d < -$signed(DEADZONE)) begin
      mag = 12'(-d - $signed(DEADZONE));
    end else begin
      mag = '0;
    end
    t  = {rem_r, q_r[NORM_BITS-1]};
    ge = t >= NORM_DIV;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      q_nxt   = {mag, 8'b0};
      rem_nxt = '0;
      neg_nxt = d < 0;
    end else if (ctl.step) begin
      q_nxt   = {q_r[NORM_BITS-2:0], ge};
      rem_nxt = ge ? 5'(t - NORM_DIV) : t[4:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign n = neg_r ? -$signed({1'b0, q_r[14:0]}) : $signed({1'b0, q_r[14:0]});

endmodule

// ----- rtl/rcsv_sqrt.sv -----
module rcsv_sqrt (
  input  logic                clk,
  input  rcsv_pkg::lane_ctl_t ctl,
  input  logic [45:0]         s,
  output logic [22:0]         root
);
  import rcsv_pkg::*;

  logic [45:0] s_r, s_nxt;
  logic [45:0] r_r, r_nxt;
  logic [45:0] bit_r, bit_nxt;
  logic [45:0] trial;

  always_comb begin
    trial   = r_r + bit_r;
    s_nxt   = s_r;
    r_nxt   = r_r;
    bit_nxt = bit_r;
    if (ctl.load) begin
      s_nxt   = s;
      r_nxt   = '0;
      bit_nxt = 46'(1) << 44;
    end else if (ctl.step) begin
      if (s_r >= trial) begin
        s_nxt = s_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign root = r_r[22:0];

endmodule

// ----- rtl/rcsv_div_lane.sv -----
module rcsv_div_lane (
  input  logic                clk,
  input  rcsv_pkg::lane_ctl_t ctl,
  input  logic [31:0]         num,
  input  logic                neg,
  input  logic [22:0]         den,
  output logic signed [10:0]  q
);
  import rcsv_pkg::*;

  logic [DIV_BITS-1:0] q_r, q_nxt;
  logic [22:0]         rem_r, rem_nxt;
  logic [22:0]         den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [23:0]         t;
  logic                ge;

  always_comb begin
    t  = {rem_r, q_r[DIV_BITS-1]};
    ge = t >= {1'b0, den_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      neg_nxt = neg;
    end else if (ctl.step) begin
      q_nxt   = {q_r[DIV_BITS-2:0], ge};
      rem_nxt = ge ? 23'(t - {1'b0, den_r}) : t[22:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign q = neg_r ? -$signed({1'b0, q_r[9:0]}) : $signed({1'b0, q_r[9:0]});

endmodule

// ----- tb/tb.sv -----
module tb;
  import rcsv_pkg::*;

  typedef struct {
    logic [11:0]        roll, pitch, thr, yaw, sw;
    logic signed [15:0] pvx, pvy, pvz, pdx, pdy, pdz, mh;
  } frame_t;

  typedef struct {
    logic signed [10:0] vx, vy, vz;
    logic signed [15:0] dx, dy, dz;
    mode_t              mode;
  } setpoint_t;

  typedef struct {
    frame_t    fr;
    bit        known;
    setpoint_t sp;
  } row_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  cfg_idx_t           cfg_idx = CFG_XY_LIMIT;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_stall;
  frame_t             drv = '{default: '0};
  logic               out_valid;
  logic               out_stall = 1;
  logic signed [10:0] out_vx, out_vy, out_vz;
  logic signed [15:0] out_dx, out_dy, out_dz;
  logic [1:0]         out_mode;

  setpoint_t setpoint_q[$];
  int        fails = 0;
  int        checked = 0;
  int        mode_seen[4] = '{0, 0, 0, 0};
  bit        idle_en = 1;

  // predictor state and register copy
  int xy_lim, zup_lim, zdn_lim, hold_lim;
  int fx, fy, fz;
  int frames;
  mode_t mode_q;

  rc_stick_velocity_setpoint_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_roll_pulse(drv.roll), .in_pitch_pulse(drv.pitch),
    .in_throttle_pulse(drv.thr), .in_yaw_pulse(drv.yaw),
    .in_switch_pulse(drv.sw),
    .in_prog_vel_x(drv.pvx), .in_prog_vel_y(drv.pvy), .in_prog_vel_z(drv.pvz),
    .in_prog_dist_x(drv.pdx), .in_prog_dist_y(drv.pdy), .in_prog_dist_z(drv.pdz),
    .in_measured_height(drv.mh),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vel_out_x(out_vx), .out_vel_out_y(out_vy), .out_vel_out_z(out_vz),
    .out_dist_out_x(out_dx), .out_dist_out_y(out_dy), .out_dist_out_z(out_dz),
    .out_flight_mode(out_mode)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int stick_units(logic [11:0] p);
    int d;
    d = int'(p) - 1500;
    if (d > 0) begin
      d -= 50;
      if (d < 0) d = 0;
    end else begin
      d += 50;
      if (d > 0) d = 0;
    end
    return (d * 256) / 25;
  endfunction

  function automatic int half_step(int f, int n);
    int diff, half;
    diff = n - f;
    half = diff >= 0 ? diff / 2 : -((-diff + 1) / 2);
    f += half;
    if (f > 4096) f = 4096;
    if (f < -4096) f = -4096;
    return f;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit open_rng(logic [11:0] v, int lo, int hi);
    return int'(v) > lo && int'(v) < hi;
  endfunction

  function automatic setpoint_t velocity_setpoint(frame_t f);
    setpoint_t r;
    longint vx, vy, vz, lxy, lzp, lzn, l;
    longint unsigned s;
    vx = 0; vy = 0; vz = 0;
    lxy = longint'(xy_lim) * 4096;
    lzp = longint'(zup_lim) * 4096;
    lzn = -longint'(zdn_lim) * 4096;
    if (frames < 65535) frames++;
    fx = half_step(fx, stick_units(f.roll));
    fy = half_step(fy, stick_units(f.pitch));
    fz = half_step(fz, stick_units(f.thr));
    if (open_rng(f.sw, 1800, 2200) && open_rng(f.thr, 1470, 1530) &&
        open_rng(f.yaw, 1485, 1515) && open_rng(f.pitch, 1485, 1515) &&
        open_rng(f.roll, 1485, 1515)) begin
      if (frames > hold_lim) mode_q = MODE_RT;
    end else if (open_rng(f.sw, 1300, 1700)) begin
      mode_q = MODE_HOLD;
      frames = 0;
    end else if (open_rng(f.sw, 800, 1200)) begin
      mode_q = MODE_MAN;
      frames = 0;
    end else begin
      frames = 0;
    end
    if (mode_q != MODE_NONE) begin
      vx = longint'(xy_lim) * fx;
      vy = longint'(xy_lim) * fy;
      vz = longint'(zup_lim) * fz;
      if (mode_q == MODE_RT) begin
        vx += longint'(f.pvx) * 4096;
        vy += longint'(f.pvy) * 4096;
        vz += longint'(f.pvz) * 4096;
      end
      vx = clip(vx, -lxy, lxy);
      vy = clip(vy, -lxy, lxy);
      vz = clip(vz, lzn, lzp);
    end
    s = longint'(vx * vx) + longint'(vy * vy);
    if (s > longint'(lxy * lxy)) begin
      l = longint'(floor_sqrt(s));
      vx = vx * lxy / l;
      vy = vy * lxy / l;
    end
    vz = clip(vz, lzn, lzp);
    r.vx = 11'(vx / 4096);
    r.vy = 11'(vy / 4096);
    r.vz = 11'(vz / 4096);
    r.dx = f.pdx;
    r.dy = f.pdy;
    r.dz = mode_q == MODE_HOLD ? f.mh : f.pdz;
    r.mode = mode_q;
    return r;
  endfunction

  function automatic frame_t mk(int ro, int pi, int th, int ya, int sw,
                                int vx, int vy, int vz, int dx, int dy, int dz, int mh);
    frame_t f;
    f.roll = 12'(ro); f.pitch = 12'(pi); f.thr = 12'(th); f.yaw = 12'(ya); f.sw = 12'(sw);
    f.pvx = 16'(vx); f.pvy = 16'(vy); f.pvz = 16'(vz);
    f.pdx = 16'(dx); f.pdy = 16'(dy); f.pdz = 16'(dz); f.mh = 16'(mh);
    return f;
  endfunction

  function automatic logic signed [15:0] rand_prog();
    case ($urandom_range(0, 7))
      0, 1: return 16'($urandom);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3, 4: return 16'($signed($urandom_range(0, 3000)) - 1500);
      default: return 16'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // seg: 0 centered, 1 position hold, 2 manual, 3 noise
  function automatic frame_t rand_frame(int seg);
    frame_t f;
    f.roll = 12'($urandom); f.pitch = 12'($urandom); f.thr = 12'($urandom);
    f.yaw = 12'($urandom); f.sw = 12'($urandom);
    if (seg == 0 || ($urandom_range(0, 2) == 0 && seg != 3)) begin
      f.roll = 12'($urandom_range(1486, 1514));
      f.pitch = 12'($urandom_range(1486, 1514));
      f.yaw = 12'($urandom_range(1486, 1514));
      f.thr = 12'($urandom_range(1471, 1529));
    end else if (seg != 3) begin
      f.roll = 12'($urandom_range(1000, 2000));
      f.pitch = 12'($urandom_range(1000, 2000));
      f.thr = 12'($urandom_range(1000, 2000));
    end
    case (seg)
      0: f.sw = 12'($urandom_range(1801, 2199));
      1: f.sw = 12'($urandom_range(1301, 1699));
      2: f.sw = 12'($urandom_range(801, 1199));
      default: ;
    endcase
    // break a centered run now and then
    if (seg == 0 && $urandom_range(0, 19) == 0) f.yaw = 12'($urandom);
    f.pvx = rand_prog(); f.pvy = rand_prog(); f.pvz = rand_prog();
    f.pdx = 16'($urandom); f.pdy = 16'($urandom); f.pdz = 16'($urandom);
    f.mh = 16'($urandom);
    return f;
  endfunction

  function automatic int draw_wait();
    if (!idle_en || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send_frame(frame_t f, bit known, setpoint_t typed);
    int gap;
    setpoint_t p;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    drv <= f;
    do @(posedge clk); while (in_stall);
    p = velocity_setpoint(f);
    mode_seen[p.mode]++;
    setpoint_q.push_back(known ? typed : p);
  endtask

  task automatic write_regs(int xy, int zu, int zd, int hold);
    in_valid <= 0;
    while (setpoint_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= CFG_XY_LIMIT; cfg_wdata <= 16'(xy); @(posedge clk);
    cfg_idx <= CFG_Z_UP;     cfg_wdata <= 16'(zu); @(posedge clk);
    cfg_idx <= CFG_Z_DOWN;   cfg_wdata <= 16'(zd); @(posedge clk);
    cfg_idx <= CFG_HOLD;     cfg_wdata <= 16'(hold); @(posedge clk);
    cfg_we <= 0;
    xy_lim = xy; zup_lim = zu; zdn_lim = zd; hold_lim = hold;
  endtask

  // result side: random stall, compare against oldest expectation
  initial begin
    int hold_off;
    setpoint_t e;
    hold_off = draw_wait();
    forever begin
      out_stall <= hold_off > 0;
      @(posedge clk);
      if (out_valid && !out_stall) begin
        checked++;
        if (setpoint_q.size() == 0) begin
          $error("transaction with no expectation waiting");
          fails++;
        end else begin
          e = setpoint_q.pop_front();
          if (out_vx !== e.vx) begin
            $error("vel_out_x exp %0d got %0d", e.vx, out_vx); fails++;
          end
          if (out_vy !== e.vy) begin
            $error("vel_out_y exp %0d got %0d", e.vy, out_vy); fails++;
          end
          if (out_vz !== e.vz) begin
            $error("vel_out_z exp %0d got %0d", e.vz, out_vz); fails++;
          end
          if (out_dx !== e.dx) begin
            $error("dist_out_x exp %0d got %0d", e.dx, out_dx); fails++;
          end
          if (out_dy !== e.dy) begin
            $error("dist_out_y exp %0d got %0d", e.dy, out_dy); fails++;
          end
          if (out_dz !== e.dz) begin
            $error("dist_out_z exp %0d got %0d", e.dz, out_dz); fails++;
          end
          if (out_mode !== e.mode) begin
            $error("flight_mode exp %0d got %0d", e.mode, out_mode); fails++;
          end
        end
        hold_off = draw_wait();
      end else if (hold_off > 0) begin
        hold_off--;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int cfgs[6][4] = '{'{1000, 1000, 1000, 0}, '{0, 0, 0, 5}, '{1, 1000, 0, 20},
                       '{1000, 0, 1000, 65535}, '{300, 200, 700, 10},
                       '{700, 500, 50, 2}};
    int seg, seg_len;

    xy_lim = 500; zup_lim = 350; zdn_lim = 250; hold_lim = 1000;
    fx = 0; fy = 0; fz = 0; frames = 0; mode_q = MODE_NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // no mode yet: velocities zero, distances pass through
    r.known = 1;
    r.fr = mk(1500, 1500, 1500, 1500, 0, 100, 100, 100, 32767, -32768, 123, 77);
    r.sp = '{0, 0, 0, 32767, -32768, 123, MODE_NONE};
    rows.push_back(r);
    r.fr = mk(4095, 4095, 4095, 4095, 4095, 32767, -32768, 5, -1, 0, -32768, 9);
    r.sp = '{0, 0, 0, -1, 0, -32768, MODE_NONE};
    rows.push_back(r);
    r.known = 0;
    r.fr = mk(0, 0, 0, 0, 1000, 0, 0, 0, 1, 2, 3, 4);              rows.push_back(r);
    r.fr = mk(4095, 4095, 4095, 4095, 1000, 0, 0, 0, 1, 2, 3, 4);  rows.push_back(r);
    r.fr = mk(0, 0, 0, 0, 1500, 0, 0, 0, 5, 6, 7, -32768);         rows.push_back(r);
    r.fr = mk(4095, 0, 4095, 0, 1500, 0, 0, 0, 5, 6, 7, 32767);    rows.push_back(r);
    r.fr = mk(1450, 1550, 1449, 1551, 1500, 0, 0, 0, 0, 0, 0, 1);  rows.push_back(r);
    r.fr = mk(1551, 1449, 1550, 1450, 1300, 0, 0, 0, 0, 0, 0, 1);  rows.push_back(r);
    r.fr = mk(1500, 1500, 1500, 1500, 1700, 0, 0, 0, 0, 0, 0, 1);  rows.push_back(r);
    r.fr = mk(1500, 1500, 1500, 1500, 800, 0, 0, 0, 0, 0, 0, 1);   rows.push_back(r);
    r.fr = mk(1500, 1500, 1500, 1500, 1200, 0, 0, 0, 0, 0, 0, 1);  rows.push_back(r);
    r.fr = mk(1500, 1500, 1500, 1500, 1199, 0, 0, 0, 0, 0, 0, 1);  rows.push_back(r);
    for (int i = 0; i < 6; i++) begin
      r.fr = mk(1500, 1486, 1514, 1500, 2000, i[0] ? 32767 : -32768,
                i[1] ? -32768 : 32767, i[0] ? -32768 : 32767, 0, 0, 0, 0);
      rows.push_back(r);
    end
    r.fr = mk(1485, 1500, 1500, 1500, 2000, 200, 200, 200, 0, 0, 0, 0); rows.push_back(r);
    r.fr = mk(1500, 1500, 1470, 1515, 1800, 200, 200, 200, 0, 0, 0, 0); rows.push_back(r);
    r.fr = mk(1500, 1500, 1529, 1500, 2200, 200, 200, 200, 0, 0, 0, 0); rows.push_back(r);
    r.fr = mk(1500, 1500, 1500, 1500, 2199, -900, 400, -1, 0, 0, 0, 0); rows.push_back(r);

    write_regs(500, 350, 250, 3);
    foreach (rows[i]) send_frame(rows[i].fr, rows[i].known, rows[i].sp);

    for (int ph = 0; ph < 6; ph++) begin
      write_regs(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      idle_en = ph != 4;
      seg_len = 0;
      for (int n = 0; n < 105; n++) begin
        if (seg_len == 0) begin
          seg = $urandom_range(0, 9);
          seg = seg < 6 ? 0 : seg - 6;
          seg_len = $urandom_range(1, 40);
        end
        seg_len--;
        send_frame(rand_frame(seg), 0, '{0, 0, 0, 0, 0, 0, MODE_NONE});
      end
    end
    in_valid <= 0;

    while (setpoint_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d frames over 7 register settings", checked);
    $display("Frames by mode: none %0d, real-time %0d, hold %0d, manual %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rcsv_pkg.sv
rtl/rcsv_norm_lane.sv
rtl/rcsv_sqrt.sv
rtl/rcsv_div_lane.sv
rtl/rc_stick_velocity_setpoint_top.sv
tb/tb.sv
